@@ design/pphex_pkg.sv @@
// Shared types, constants and helpers for the pixel pack hex encoder.
// Depends on nothing; every module of the block imports it.
`timescale 1ns / 1ps

package pphex_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_DEPTH_MODE = 2'd0;
    localparam logic [1:0] CFG_LINE_WIDTH = 2'd1;

    // Reset values of the configuration registers
    localparam logic [1:0] DEPTH_MODE_RESET = 2'd3;
    localparam logic [7:0] LINE_WIDTH_RESET = 8'd50;

    // ASCII codes
    localparam logic [6:0] CHAR_NEWLINE = 7'd10;
    localparam logic [6:0] CHAR_ZERO    = 7'h30;
    localparam logic [6:0] CHAR_A_LESS10 = 7'h57;   // 'a' - 10

    // Number of entries in the nibble queue
    localparam int unsigned QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [7:0] pixel;
        logic       row_end;
    } t_in_item;

    typedef struct packed {
        logic [6:0] out_char;
        logic       last_of_run;
    } t_out_item;

    // Configuration write as seen by the front and back parts
    typedef struct packed {
        logic       valid;
        logic [1:0] index;
        logic [7:0] data;
    } t_cfg_wr;

    // One queue entry: the nibbles produced by one item (one or two)
    typedef struct packed {
        logic       two;
        logic [3:0] nib0;
        logic [3:0] nib1;
    } t_nib_entry;

    // Lower-case ASCII hex digit of a nibble
    function automatic logic [6:0] hex_char(input logic [3:0] nib);
        logic [6:0] wide;
        begin
            wide = {3'b000, nib};
            hex_char = (nib < 4'd10) ? (CHAR_ZERO + wide) : (CHAR_A_LESS10 + wide);
        end
    endfunction

endpackage

@@ design/pphex_front.sv @@
// Front part: accepts pixel items, reduces and packs their bits into nibbles,
// handles row-end padding. Depends on pphex_pkg.
`timescale 1ns / 1ps

module pphex_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pphex_pkg::t_cfg_wr    i_cfg,
    input  logic                  i_accept,
    input  pphex_pkg::t_in_item   i_item,
    output logic                  o_enq,
    output pphex_pkg::t_nib_entry o_entry
);
    import pphex_pkg::*;

    logic [1:0] r_depth_mode;
    logic [3:0] r_nibble_acc;
    logic [1:0] r_bits_in_nibble;
    logic       r_odd_nibble;

    logic [1:0] n_depth_mode;
    logic [3:0] n_nibble_acc;
    logic [1:0] n_bits_in_nibble;
    logic       n_odd_nibble;

    logic [3:0] acc;
    logic [2:0] bits;
    logic       odd;
    logic [1:0] cnt;
    logic [3:0] nibs [2];
    logic [3:0] nbits;
    logic [3:0] pad;
    logic [3:0] acc_sh;

    // Pack the item's top bits one at a time, then close the row if marked
    always_comb begin
        acc   = r_nibble_acc;
        bits  = {1'b0, r_bits_in_nibble};
        odd   = r_odd_nibble;
        cnt   = 2'd0;
        nibs[0] = 4'd0;
        nibs[1] = 4'd0;
        nbits = 4'd1 << r_depth_mode;
        pad   = 4'd0;
        acc_sh = 4'd0;

        for (int i = 0; i < 8; i++) begin
            if (4'(i) < nbits) begin
                acc_sh = {acc[2:0], i_item.pixel[7 - i]};
                if (bits == 3'd3) begin
                    nibs[cnt[0]] = acc_sh;
                    cnt  = cnt + 2'd1;
                    odd  = ~odd;
                    acc  = 4'd0;
                    bits = 3'd0;
                end else begin
                    acc  = acc_sh;
                    bits = bits + 3'd1;
                end
            end
        end

        if (i_item.row_end) begin
            // partly filled nibble gets zero bits at the bottom
            if (bits != 3'd0) begin
                case (bits[1:0])
                    2'd1:    pad = {acc[0], 3'b000};
                    2'd2:    pad = {acc[1:0], 2'b00};
                    2'd3:    pad = {acc[2:0], 1'b0};
                    default: pad = 4'd0;
                endcase
                nibs[cnt[0]] = pad;
                cnt = cnt + 2'd1;
                odd = ~odd;
            end
            // odd nibble count: add a zero digit to finish the byte
            if (odd) begin
                nibs[cnt[0]] = 4'd0;
                cnt = cnt + 2'd1;
            end
            odd  = 1'b0;
            acc  = 4'd0;
            bits = 3'd0;
        end
    end

    assign o_enq        = i_accept && (cnt != 2'd0);
    assign o_entry.two  = cnt[1];
    assign o_entry.nib0 = nibs[0];
    assign o_entry.nib1 = nibs[1];

    // Next state: a depth write drops the partial row
    always_comb begin
        n_depth_mode     = r_depth_mode;
        n_nibble_acc     = r_nibble_acc;
        n_bits_in_nibble = r_bits_in_nibble;
        n_odd_nibble     = r_odd_nibble;
        if (i_cfg.valid && i_cfg.index == CFG_DEPTH_MODE) begin
            n_depth_mode     = i_cfg.data[1:0];
            n_nibble_acc     = 4'd0;
            n_bits_in_nibble = 2'd0;
            n_odd_nibble     = 1'b0;
        end else if (i_accept) begin
            n_nibble_acc     = acc;
            n_bits_in_nibble = bits[1:0];
            n_odd_nibble     = odd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth_mode     <= DEPTH_MODE_RESET;
            r_nibble_acc     <= 4'd0;
            r_bits_in_nibble <= 2'd0;
            r_odd_nibble     <= 1'b0;
        end else begin
            r_depth_mode     <= n_depth_mode;
            r_nibble_acc     <= n_nibble_acc;
            r_bits_in_nibble <= n_bits_in_nibble;
            r_odd_nibble     <= n_odd_nibble;
        end
    end

endmodule

@@ design/pphex_queue.sv @@
// Two-entry queue of nibble groups between front and back parts.
// Depends on pphex_pkg.
`timescale 1ns / 1ps

module pphex_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_enq,
    input  pphex_pkg::t_nib_entry i_entry,
    input  logic                  i_deq,
    output logic                  o_full,
    output logic                  o_empty,
    output pphex_pkg::t_nib_entry o_head
);
    import pphex_pkg::*;

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

    t_nib_entry       r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [PTR_W:0]   r_count;

    assign o_full  = (r_count == (PTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rptr];

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_enq) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_enq) begin
                r_wptr <= (r_wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_deq) begin
                r_rptr <= (r_rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            case ({i_enq, i_deq})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ design/pphex_back.sv @@
// Back part: turns queued nibbles into hex characters, inserts newlines by
// column count, and holds the output register. Depends on pphex_pkg.
`timescale 1ns / 1ps

module pphex_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pphex_pkg::t_cfg_wr    i_cfg,
    input  logic                  i_q_empty,
    input  pphex_pkg::t_nib_entry i_q_head,
    output logic                  o_deq,
    input  logic                  i_pop,
    output logic                  o_empty,
    output pphex_pkg::t_out_item  o_item
);
    import pphex_pkg::*;

    typedef enum logic [1:0] {
        PH_NIB0,
        PH_NL0,
        PH_NIB1,
        PH_NL1
    } t_phase;

    t_phase     r_phase;
    t_phase     n_phase;
    logic [7:0] r_line_width;
    logic [7:0] r_column;
    logic [7:0] n_column;
    logic       r_out_valid;
    t_out_item  r_out;
    t_out_item  n_out;

    logic       load;
    logic       last_nib;
    logic       is_nl;
    logic [3:0] cur_nib;
    logic [7:0] col_inc;
    logic       need_nl;

    assign load     = !i_q_empty && (!r_out_valid || i_pop);
    assign last_nib = (r_phase == PH_NIB1) || (r_phase == PH_NL1) || !i_q_head.two;
    assign is_nl    = (r_phase == PH_NL0) || (r_phase == PH_NL1);
    assign cur_nib  = (r_phase == PH_NIB1) ? i_q_head.nib1 : i_q_head.nib0;
    assign col_inc  = r_column + 8'd1;
    assign need_nl  = (col_inc >= r_line_width);

    // Next character, column and phase
    always_comb begin
        n_phase  = r_phase;
        n_column = r_column;
        n_out    = r_out;
        o_deq    = 1'b0;
        if (load) begin
            if (is_nl) begin
                n_out.out_char    = CHAR_NEWLINE;
                n_out.last_of_run = last_nib;
                o_deq             = last_nib;
                n_phase           = last_nib ? PH_NIB0 : PH_NIB1;
            end else begin
                n_out.out_char    = hex_char(cur_nib);
                n_out.last_of_run = last_nib && !need_nl;
                n_column          = need_nl ? 8'd0 : col_inc;
                o_deq             = last_nib && !need_nl;
                if (need_nl) begin
                    n_phase = (r_phase == PH_NIB1) ? PH_NL1 : PH_NL0;
                end else begin
                    n_phase = last_nib ? PH_NIB0 : PH_NIB1;
                end
            end
        end
    end

    // State and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_NIB0;
            r_column     <= 8'd0;
            r_line_width <= LINE_WIDTH_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_column <= n_column;
            if (i_cfg.valid && i_cfg.index == CFG_LINE_WIDTH) begin
                r_line_width <= i_cfg.data;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
        r_out <= n_out;
    end

    assign o_empty = !r_out_valid;
    assign o_item  = r_out;

endmodule

@@ design/pixel_pack_hex_encoder.sv @@
// Top level of the pixel pack hex encoder: front packer, nibble queue and
// character back end. Depends on pphex_pkg, pphex_front, pphex_queue, pphex_back.
`timescale 1ns / 1ps

// Usage:
//   Input queue side: drive i_in_item and raise push; the item is taken at a
//   clock edge where push is high and full is low. Each item carries an
//   8-bit pixel and a row_end mark.
//   Output queue side: while empty is low, o_out_item holds the oldest
//   character (hex digit or newline) with last_of_run set on the final
//   character of an item; raise pop to take it.
//   Config: i_cfg_valid with i_cfg_index/i_cfg_data; o_cfg_ready is always
//   high. Index 0 sets depth_mode (clears any partly packed row), index 1
//   sets line_width. Write only while the block is idle.
// Timing: a taken item's nibbles are written into the nibble queue as it is taken,
//   and the back end then loads its first character into the output register
//   once that register is free. The back end sends one character per cycle while
//   pop is high and the queue holds nibbles; an item yields up to 4 characters
//   (two digits and two newlines at 8 bits per pixel), about 2 on average at 8
//   bits per pixel. A two-entry nibble queue lets the input side keep taking items.
// Reset: synchronous, active low; queues empty, depth_mode 3, line_width 50.
// Stall: with pop low the output register holds; the queue then fills and
//   full rises, holding off every item until pops let the back end free an entry.
module pixel_pack_hex_encoder (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  pphex_pkg::t_in_item  i_in_item,
    output logic                 empty,
    input  logic                 pop,
    output pphex_pkg::t_out_item o_out_item,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [7:0]           i_cfg_data
);
    import pphex_pkg::*;

    t_cfg_wr    cfg;
    logic       accept;
    logic       enq;
    logic       deq;
    logic       q_empty;
    t_nib_entry entry;
    t_nib_entry head;

    assign o_cfg_ready = 1'b1;
    assign cfg.valid   = i_cfg_valid;
    assign cfg.index   = i_cfg_index;
    assign cfg.data    = i_cfg_data;
    assign accept      = push && !full;

    pphex_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_accept(accept),
        .i_item  (i_in_item),
        .o_enq   (enq),
        .o_entry (entry)
    );

    pphex_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_enq  (enq),
        .i_entry(entry),
        .i_deq  (deq),
        .o_full (full),
        .o_empty(q_empty),
        .o_head (head)
    );

    pphex_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_q_empty(q_empty),
        .i_q_head (head),
        .o_deq    (deq),
        .i_pop    (pop),
        .o_empty  (empty),
        .o_item   (o_out_item)
    );

endmodule

@@ bench/pixel_pack_hex_encoder_test.sv @@
// Testbench for pixel_pack_hex_encoder: predicts the hex character stream of
// every accepted pixel and checks each popped character in order.
// Depends on pphex_pkg and the pixel_pack_hex_encoder RTL.
`timescale 1ns / 1ps

module pixel_pack_hex_encoder_test;

    import pphex_pkg::*;

    localparam int          CYCLE_LIMIT   = 200000;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          IDLE_PERCENT  = 21;
    localparam logic [6:0]  ASCII_ZERO    = 7'h30;
    localparam logic [6:0]  ASCII_LOWER_A = 7'h61;

    logic       i_clk;
    logic       i_rst_n;
    logic       push;
    logic       full;
    t_in_item   i_in_item;
    logic       empty;
    logic       pop;
    t_out_item  o_out_item;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_index;
    logic [7:0] i_cfg_data;

    pixel_pack_hex_encoder DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in_item   (i_in_item),
        .empty       (empty),
        .pop         (pop),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Packer model state and its copy of the registers
    logic [1:0] pk_depth;
    logic [7:0] pk_width;
    logic [3:0] pk_acc;
    logic [1:0] pk_nbits;
    logic       pk_odd;
    logic [7:0] pk_col;

    t_out_item  expected_chars[$];
    t_out_item  step_chars[$];
    int         error_count;
    int         cycle_count;
    bit         no_idle;

    // Clock
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Watchdog
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic bit side_idles();
        return !no_idle && ($urandom_range(99) < IDLE_PERCENT);
    endfunction

    task report_mismatch(input string msg);
        begin
            $display("mismatch @%0t: %s", $realtime, msg);
            error_count++;
        end
    endtask

    // One hex digit, plus a newline when the line is full
    task put_digit(input logic [3:0] nib);
        t_out_item c;
        begin
            c.out_char    = (nib < 4'd10) ? ASCII_ZERO + {3'b000, nib}
                                          : ASCII_LOWER_A + {3'b000, nib} - 7'd10;
            c.last_of_run = 1'b0;
            step_chars.push_back(c);
            pk_odd = ~pk_odd;
            pk_col = pk_col + 8'd1;
            if (pk_col >= pk_width) begin
                c.out_char = CHAR_NEWLINE;
                step_chars.push_back(c);
                pk_col = 8'd0;
            end
        end
    endtask

    task push_bit(input logic b);
        logic [3:0] acc;
        begin
            acc = {pk_acc[2:0], b};
            if (pk_nbits == 2'd3) begin
                pk_acc   = 4'd0;
                pk_nbits = 2'd0;
                put_digit(acc);
            end else begin
                pk_acc   = acc;
                pk_nbits = pk_nbits + 2'd1;
            end
        end
    endtask

    // Expected characters of one accepted pixel
    task pack_pixel(input t_in_item it);
        int        nb;
        int        pad;
        t_out_item c;
        begin
            step_chars.delete();
            nb = 1 << pk_depth;
            for (int i = 0; i < nb; i++) push_bit(it.pixel[7 - i]);
            if (it.row_end) begin
                if (pk_nbits != 2'd0) begin
                    pad = (int'(pk_acc) << (4 - int'(pk_nbits))) & 15;
                    pk_acc   = 4'd0;
                    pk_nbits = 2'd0;
                    put_digit(pad[3:0]);
                end
                if (pk_odd) put_digit(4'd0);
                pk_odd   = 1'b0;
                pk_acc   = 4'd0;
                pk_nbits = 2'd0;
            end
            for (int i = 0; i < step_chars.size(); i++) begin
                c = step_chars[i];
                c.last_of_run = (i == step_chars.size() - 1);
                expected_chars.push_back(c);
            end
        end
    endtask

    task cfg_apply(input logic [1:0] idx, input logic [7:0] data);
        begin
            if (idx == CFG_DEPTH_MODE) begin
                pk_depth = data[1:0];
                pk_acc   = 4'd0;
                pk_nbits = 2'd0;
                pk_odd   = 1'b0;
            end else if (idx == CFG_LINE_WIDTH) begin
                pk_width = data;
            end
        end
    endtask

    // Send one item; returns at the falling edge after acceptance, push still high
    task send_pixel(input logic [7:0] px, input logic rowend);
        t_in_item it;
        begin
            it.pixel   = px;
            it.row_end = rowend;
            while (side_idles()) begin
                push = 1'b0;
                @(negedge i_clk);
            end
            push      = 1'b1;
            i_in_item = it;
            @(posedge i_clk);
            while (full) @(posedge i_clk);
            pack_pixel(it);
            @(negedge i_clk);
        end
    endtask

    // Wait for the block to go idle
    task drain_block();
        begin
            push = 1'b0;
            while (expected_chars.size() != 0) @(negedge i_clk);
            repeat (SETTLE_CYCLES) @(negedge i_clk);
        end
    endtask

    task write_reg(input logic [1:0] idx, input logic [7:0] data);
        begin
            drain_block();
            i_cfg_valid = 1'b1;
            i_cfg_index = idx;
            i_cfg_data  = data;
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            cfg_apply(idx, data);
            @(negedge i_clk);
            i_cfg_valid = 1'b0;
        end
    endtask

    // Result side: random pop, check at the rising edge
    initial begin
        pop = 1'b0;
        forever begin
            @(negedge i_clk);
            pop = i_rst_n && !side_idles();
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (expected_chars.size() == 0) begin
                report_mismatch($sformatf("unexpected char 0x%02h", o_out_item.out_char));
            end else begin
                if (o_out_item.out_char !== expected_chars[0].out_char)
                    report_mismatch($sformatf("out_char 0x%02h, expected 0x%02h",
                        o_out_item.out_char, expected_chars[0].out_char));
                if (o_out_item.last_of_run !== expected_chars[0].last_of_run)
                    report_mismatch($sformatf("last_of_run %0b, expected %0b",
                        o_out_item.last_of_run, expected_chars[0].last_of_run));
                void'(expected_chars.pop_front());
            end
        end
    end

    // Reset values of the registers
    task test_reset_values();
        begin
            send_pixel(8'h00, 1'b0);
            send_pixel(8'hff, 1'b0);
            send_pixel(8'h5a, 1'b1);
        end
    endtask

    // Each depth, with padding of partial nibbles and odd rows
    task test_depth_modes();
        begin
            write_reg(CFG_DEPTH_MODE, 8'd0);
            send_pixel(8'h80, 1'b0);
            send_pixel(8'h00, 1'b0);
            send_pixel(8'hff, 1'b1);
            write_reg(CFG_DEPTH_MODE, 8'd1);
            send_pixel(8'hc0, 1'b0);
            send_pixel(8'h40, 1'b1);
            write_reg(CFG_DEPTH_MODE, 8'd2);
            send_pixel(8'hf0, 1'b1);
            send_pixel(8'h0f, 1'b0);
            send_pixel(8'ha5, 1'b1);
            write_reg(CFG_DEPTH_MODE, 8'd3);
            send_pixel(8'hff, 1'b1);
        end
    endtask

    // Newline insertion: narrow, zero, widest, and lowered below the column
    task test_line_width();
        begin
            write_reg(CFG_LINE_WIDTH, 8'd1);
            send_pixel(8'h12, 1'b0);
            send_pixel(8'h34, 1'b1);
            write_reg(CFG_LINE_WIDTH, 8'd0);
            send_pixel(8'hab, 1'b1);
            write_reg(CFG_LINE_WIDTH, 8'd255);
            send_pixel(8'hff, 1'b0);
            send_pixel(8'hff, 1'b0);
            write_reg(CFG_LINE_WIDTH, 8'd3);
            send_pixel(8'h01, 1'b1);
        end
    endtask

    // A depth write drops a partly packed row but keeps the column
    task test_depth_write_drop();
        begin
            write_reg(CFG_DEPTH_MODE, 8'd0);
            send_pixel(8'h80, 1'b0);
            send_pixel(8'h80, 1'b0);
            write_reg(CFG_DEPTH_MODE, 8'd0);
            send_pixel(8'hff, 1'b0);
            send_pixel(8'h00, 1'b0);
            send_pixel(8'hff, 1'b0);
            send_pixel(8'h00, 1'b1);
        end
    endtask

    // Random rows over several register settings
    task test_random_rows();
        logic [7:0] widths[8];
        logic [1:0] depths[8];
        int         sent;
        int         row_len;
        logic [7:0] px;
        logic       rowend;
        begin
            widths = '{8'd1, 8'd255, 8'd0, 8'd7, 8'd2, 8'd13, 8'd50, 8'd128};
            depths = '{2'd3, 2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd2, 2'd1};
            for (int ph = 0; ph < 8; ph++) begin
                if (ph >= 3) widths[ph] = 8'($urandom_range(1, 255));
                if (ph == 6) widths[ph] = 8'd50;
                write_reg(CFG_LINE_WIDTH, widths[ph]);
                write_reg(CFG_DEPTH_MODE, {6'd0, depths[ph]});
                no_idle = (ph == 5);
                sent = 0;
                while (sent < 35) begin
                    row_len = $urandom_range(1, 12);
                    for (int k = 0; k < row_len && sent < 35; k++) begin
                        case ($urandom_range(9))
                            0:       px = 8'h00;
                            1:       px = 8'hff;
                            default: px = 8'($urandom_range(255));
                        endcase
                        // mostly clean rows, some stray row ends
                        if ($urandom_range(9) == 0) rowend = 1'($urandom_range(1));
                        else rowend = (k == row_len - 1);
                        send_pixel(px, rowend);
                        sent++;
                    end
                end
                no_idle = 1'b0;
            end
        end
    endtask

    // Sequence
    initial begin
        error_count = 0;
        no_idle     = 1'b0;
        i_rst_n     = 1'b0;
        push        = 1'b0;
        i_in_item   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_DEPTH_MODE;
        i_cfg_data  = 8'd0;
        pk_depth    = DEPTH_MODE_RESET;
        pk_width    = LINE_WIDTH_RESET;
        pk_acc      = 4'd0;
        pk_nbits    = 2'd0;
        pk_odd      = 1'b0;
        pk_col      = 8'd0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_reset_values();
        test_depth_modes();
        test_line_width();
        test_depth_write_drop();
        test_random_rows();

        drain_block();
        repeat (20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
